@@ hw/rtl/modexp_pkg.sv @@
// shared types and constants for the modular exponentiation block
`default_nettype none
package modexp_pkg;
  // datapath commands from the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RED_STEP,
    CMD_MUL_START_ACC,
    CMD_MUL_START_SQR,
    CMD_MUL_STEP,
    CMD_MUL_END_ACC,
    CMD_MUL_END_SQR
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic step_last;
  } status_t;
endpackage
`default_nettype wire

@@ hw/rtl/modexp_if.sv @@
// valid/ready channel interfaces
`default_nettype none
interface modexp_in_if #(parameter int WIDTH = 64) (input wire logic clk);
  logic valid;
  logic ready;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent_value;
  logic [WIDTH-1:0] modulus_value;
  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface modexp_out_if #(parameter int WIDTH = 64) (input wire logic clk);
  logic valid;
  logic ready;
  logic [WIDTH-1:0] power_result;
  logic modulus_error;
  modport source (output valid, power_result, modulus_error, input ready);
  modport sink (input valid, power_result, modulus_error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/modular_exponentiation.sv @@
// top level of the modular exponentiation block
//
// computes base^exponent mod modulus by right-to-left square and multiply
// input channel in: base_value, exponent_value, modulus_value (valid/ready)
// output channel out: power_result, modulus_error (valid/ready)
// one transaction in gives exactly one transaction out, one item at a time
// after accept the modulus is checked, then the base is reduced bit by bit
// each exponent bit starts in the decide state; the serial shift-add multiplier
// runs one square for a clear bit and a multiply plus a square for a set bit
// a zero exponent skips the multiplies and gives result 1, and a zero modulus
// skips the reduction and gives result 0 with modulus_error set
// in.ready is low while an item is in flight or its result waits on out
// the result is held stable while out stalls
// synchronous reset returns to idle and drops out.valid
`default_nettype none
module modular_exponentiation import modexp_pkg::*; #(
  parameter int WIDTH = 64
) (
  input wire logic       clk,
  input wire logic       rst,
  modexp_in_if.sink      in,
  modexp_out_if.source   out
);
  cmd_t             cmd;
  status_t          status;
  logic             err, take, ovalid;
  logic [WIDTH-1:0] acc;

  modexp_ctrl u_ctrl (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(ovalid), .out_ready(out.ready), .err, .take, .status, .cmd
  );

  modexp_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk, .cmd, .base_in(in.base_value), .exp_in(in.exponent_value),
    .mod_in(in.modulus_value), .status, .result(acc)
  );

  assign out.valid = ovalid;
  assign out.modulus_error = err;
  assign out.power_result = err ? '0 : acc;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    take |=> !out.valid) else $error("output valid during new item");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.power_result))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> !in.ready) else $error("accepted while busy");
endmodule
`default_nettype wire

@@ hw/rtl/modexp_datapath.sv @@
// operand registers, serial modular multiplier and bitwise base reduction
`default_nettype none
module modexp_datapath import modexp_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire cmd_t             cmd,
  input  wire logic [WIDTH-1:0] base_in,
  input  wire logic [WIDTH-1:0] exp_in,
  input  wire logic [WIDTH-1:0] mod_in,
  output status_t               status,
  output logic [WIDTH-1:0]      result
);
  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] base, expo, modu, acc, prod, mult;
  logic [WIDTH-1:0] rem, rem_next;
  logic [CW-1:0]    bitc;
  logic [WIDTH:0]   dbl, dbl_red, addv, add_red, rem2;
  logic [WIDTH-1:0] p1;

  // one step of shift-add: prod = 2*prod (+ base) mod m
  always_comb begin
    dbl = {prod, 1'b0};
    dbl_red = (dbl >= {1'b0, modu}) ? dbl - {1'b0, modu} : dbl;
    p1 = dbl_red[WIDTH-1:0];
    addv = {1'b0, p1} + {1'b0, base};
    add_red = (addv >= {1'b0, modu}) ? addv - {1'b0, modu} : addv;
    // restoring reduction of the base, one bit per step
    rem2 = {rem, base[WIDTH-1]};
    rem_next = (rem2 >= {1'b0, modu}) ? WIDTH'(rem2 - {1'b0, modu}) : rem2[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        base <= base_in;
        expo <= exp_in;
        modu <= mod_in;
        acc  <= {{(WIDTH-1){1'b0}}, 1'b1};
        rem  <= '0;
        bitc <= CW'(WIDTH-1);
      end
      CMD_RED_STEP: begin
        rem  <= rem_next;
        // last step leaves the reduced base in place
        base <= (bitc == '0) ? rem_next : {base[WIDTH-2:0], 1'b0};
        bitc <= bitc - CW'(1);
      end
      CMD_MUL_START_ACC: begin
        prod <= '0;
        mult <= acc;
        bitc <= CW'(WIDTH-1);
      end
      CMD_MUL_START_SQR: begin
        prod <= '0;
        mult <= base;
        bitc <= CW'(WIDTH-1);
      end
      CMD_MUL_STEP: begin
        prod <= mult[WIDTH-1] ? add_red[WIDTH-1:0] : p1;
        mult <= {mult[WIDTH-2:0], 1'b0};
        bitc <= bitc - CW'(1);
      end
      CMD_MUL_END_ACC: begin
        // store the product and start squaring the base right away
        acc  <= prod;
        prod <= '0;
        mult <= base;
        bitc <= CW'(WIDTH-1);
      end
      CMD_MUL_END_SQR: begin
        base <= prod;
        expo <= expo >> 1;
      end
      default: begin
      end
    endcase
  end

  assign status.mod_zero  = (modu == '0);
  assign status.exp_zero  = (expo == '0);
  assign status.exp_lsb   = expo[0];
  assign status.step_last = (bitc == '0);
  assign result = acc;
endmodule
`default_nettype wire

@@ hw/rtl/modexp_ctrl.sv @@
// sequencer for reduction, square and multiply
`default_nettype none
module modexp_ctrl import modexp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic         err,
  output logic         take,
  input  wire status_t status,
  output cmd_t         cmd
);
  typedef enum logic [2:0] {IDLE, CHECK, REDUCE, DECIDE, MUL, MEND, DONE} state_t;
  state_t state;
  logic   sqr;

  always_comb begin
    unique case (state)
      IDLE:   cmd = take ? CMD_LOAD : CMD_NONE;
      REDUCE: cmd = CMD_RED_STEP;
      DECIDE: cmd = status.exp_zero ? CMD_NONE :
                    (status.exp_lsb ? CMD_MUL_START_ACC : CMD_MUL_START_SQR);
      MUL:    cmd = CMD_MUL_STEP;
      MEND:   cmd = sqr ? CMD_MUL_END_SQR : CMD_MUL_END_ACC;
      default: cmd = CMD_NONE;
    endcase
  end

  // a new item waits until the previous result has left
  assign in_ready = (state == IDLE) && !out_valid;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; out_valid <= 1'b0; err <= 1'b0; sqr <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE:   if (take) state <= CHECK;
        CHECK: begin
          if (status.mod_zero) begin err <= 1'b1; state <= DONE; end
          else begin err <= 1'b0; state <= REDUCE; end
        end
        REDUCE: if (status.step_last) state <= DECIDE;
        DECIDE: begin
          if (status.exp_zero) state <= DONE;
          else begin sqr <= !status.exp_lsb; state <= MUL; end
        end
        MUL:    if (status.step_last) state <= MEND;
        // after the multiply the square follows on the same bit
        MEND: begin
          sqr <= 1'b1;
          state <= sqr ? DECIDE : MUL;
        end
        DONE: begin out_valid <= 1'b1; state <= IDLE; end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
